>>> src/rva_pkg.sv
// Package for the axis-angle vector rotation block.
// Holds widths, fixed-point constants, the CORDIC arctangent table and helpers.
`default_nettype none
package rva_pkg;
	localparam int COMP_WIDTH  = 24;
	localparam int FRAC_BITS   = 16;
	localparam int ANGLE_BITS  = 16;
	localparam int UNIT_FRAC   = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS  = 31;
	localparam int DIV_STEPS   = 31;
	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
	localparam logic signed [32:0] UNIT_ONE = 33'sd1073741824;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] t;
		case (i)
			0: t = 34'sh20000000;  1: t = 34'sh12E4051E;  2: t = 34'sh09FB385B;
			3: t = 34'sh051111D4;  4: t = 34'sh028B0D43;  5: t = 34'sh0145D7E1;
			6: t = 34'sh00A2F61E;  7: t = 34'sh00517C55;  8: t = 34'sh0028BE53;
			9: t = 34'sh00145F2F;  10: t = 34'sh000A2F98; 11: t = 34'sh000517CC;
			12: t = 34'sh00028BE6; 13: t = 34'sh000145F3; 14: t = 34'sh0000A2FA;
			15: t = 34'sh0000517D; 16: t = 34'sh000028BE; 17: t = 34'sh0000145F;
			18: t = 34'sh00000A30; 19: t = 34'sh00000518; 20: t = 34'sh0000028C;
			21: t = 34'sh00000146; 22: t = 34'sh000000A3; 23: t = 34'sh00000051;
			24: t = 34'sh00000029; 25: t = 34'sh00000014; 26: t = 34'sh0000000A;
			27: t = 34'sh00000005; 28: t = 34'sh00000003; 29: t = 34'sh00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

	// Q1.30 product rounded: (a*b + 2^29) >>> 30
	function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b + (68'sd1 <<< (UNIT_FRAC - 1));
		return 34'(p >>> UNIT_FRAC);
	endfunction
endpackage
`default_nettype wire

>>> src/rva_if.sv
// Valid/ready channel carrying one request payload.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface rva_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/rva_front.sv
// Front end: accepts requests, classifies a zero axis, normalizes axis scale.
// Depends on rva_pkg. Two registered stages feed the queue.
`default_nettype none
module rva_front #(
	parameter int CW = rva_pkg::COMP_WIDTH,
	parameter int AW = rva_pkg::ANGLE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [CW-1:0] vx, vy, vz, ax, ay, az,
	input  wire logic [AW-1:0] ang,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [CW*3-1:0] out_v,
	output logic [31:0] out_m0, out_m1, out_m2,
	output logic [2:0] out_neg,
	output logic out_zero,
	output logic [AW-1:0] out_ang
);
	localparam int MW = (CW > 31) ? CW : 31;
	logic v_s1, v_s2;
	logic adv1, adv2;
	logic [CW*3-1:0] vec_s1, vec_s2;
	logic [MW-1:0] mag_s1 [3];
	logic [MW-1:0] top_s1;
	logic [2:0] neg_s1, neg_s2;
	logic zero_s1, zero_s2;
	logic [AW-1:0] ang_s1, ang_s2;
	logic [31:0] mn_s2 [3];
	logic [MW-1:0] mag_c [3];
	logic [MW-1:0] top_c;
	logic signed [CW:0] ai [3];
	logic [5:0] lz;
	logic [31:0] mn_c [3];

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		ai[0] = {ax[CW-1], ax}; ai[1] = {ay[CW-1], ay}; ai[2] = {az[CW-1], az};
		for (int i = 0; i < 3; i++)
			mag_c[i] = MW'(ai[i][CW] ? -ai[i] : ai[i]);
		top_c = mag_c[0] | mag_c[1] | mag_c[2];
	end

	// Shift so the top set bit lands at bit 29 (truncating when shifting down).
	always_comb begin
		lz = '0;
		for (int b = 0; b < MW; b++)
			if (top_s1[b]) lz = 6'(b);
		for (int i = 0; i < 3; i++) begin
			if (lz >= 6'd29)
				mn_c[i] = 32'(mag_s1[i] >> (lz - 6'd29));
			else
				mn_c[i] = 32'(mag_s1[i] << (6'd29 - lz));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			vec_s1 <= {vz, vy, vx};
			for (int i = 0; i < 3; i++) mag_s1[i] <= mag_c[i];
			top_s1 <= top_c;
			neg_s1 <= {az[CW-1], ay[CW-1], ax[CW-1]};
			zero_s1 <= (top_c == '0);
			ang_s1 <= ang;
		end
		if (adv2 && v_s1) begin
			vec_s2 <= vec_s1;
			for (int i = 0; i < 3; i++) mn_s2[i] <= mn_c[i];
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
			ang_s2 <= ang_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_v = vec_s2;
	assign out_m0 = mn_s2[0];
	assign out_m1 = mn_s2[1];
	assign out_m2 = mn_s2[2];
	assign out_neg = neg_s2;
	assign out_zero = zero_s2;
	assign out_ang = ang_s2;
endmodule
`default_nettype wire

>>> src/rva_queue.sv
// Short FIFO between front and back ends.
// Depends on nothing; width and depth are parameters.
`default_nettype none
module rva_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [W-1:0] in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [W-1:0] out_data
);
	localparam int AB = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AB-1:0] wp_q, rp_q;
	logic [AB:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AB+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AB'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AB'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AB+1)'(push) - (AB+1)'(pop);
		end
	end

	always_ff @(posedge clk)
		if (push) mem_q[wp_q] <= in_data;
endmodule
`default_nettype wire

>>> src/rva_back.sv
// Back end: pipelined square root, unit-axis division, CORDIC, matrix, product.
// Depends on rva_pkg. One step per stage; takes a request every cycle unless the output stalls.
`default_nettype none
module rva_back #(
	parameter int CW = rva_pkg::COMP_WIDTH,
	parameter int AW = rva_pkg::ANGLE_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [CW*3-1:0] in_v,
	input  wire logic [31:0] in_m0, in_m1, in_m2,
	input  wire logic [2:0] in_neg,
	input  wire logic in_zero,
	input  wire logic [AW-1:0] in_ang,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [CW-1:0] rx, ry, rz,
	output logic zero
);
	localparam int NS = rva_pkg::SQRT_STEPS;
	localparam int ND = rva_pkg::DIV_STEPS;
	localparam int NC = rva_pkg::CORDIC_STEPS;
	localparam int MF = (CW > 30) ? 60 - CW : 30;
	localparam int SH = 30 - MF;
	// stage layout
	localparam int P0 = 2;            // sum of squares registered
	localparam int P1 = P0 + NS;      // root done
	localparam int P2 = P1 + ND;      // division done
	localparam int NST = P2 + 6;

	typedef struct packed {
		logic [CW*3-1:0] v;
		logic [2:0] neg;
		logic zero;
	} side_t;

	logic en;
	logic [NST-1:0] vld_q;
	side_t sd [NST+1];
	assign en = !vld_q[NST-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NST-2:0], in_valid};
	end
	assign sd[0] = '{v: in_v, neg: in_neg, zero: in_zero};
	for (genvar g = 0; g < NST; g++) begin : g_side
		side_t r_q;
		always_ff @(posedge clk) if (en) r_q <= sd[g];
		assign sd[g+1] = r_q;
	end

	// magnitudes carried through root and divide
	logic [29:0] mg [P2+1][3];
	assign mg[0][0] = in_m0[29:0];
	assign mg[0][1] = in_m1[29:0];
	assign mg[0][2] = in_m2[29:0];
	for (genvar g = 0; g < P2; g++) begin : g_mag
		logic [29:0] r_q [3];
		always_ff @(posedge clk) if (en) r_q <= mg[g];
		assign mg[g+1] = r_q;
	end

	// squares then sum
	logic [59:0] sq_s1 [3];
	logic [61:0] ss_s2;
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) sq_s1[i] <= 60'(mg[0][i]) * 60'(mg[0][i]);
		ss_s2 <= 62'(sq_s1[0]) + 62'(sq_s1[1]) + 62'(sq_s1[2]);
	end

	// square root, one result bit per stage; top bit of n is 58 to 61 for a nonzero axis
	logic [63:0] sr_rem [NS+1];
	logic [63:0] sr_res [NS+1];
	assign sr_rem[0] = 64'(ss_s2);
	assign sr_res[0] = '0;
	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (60 - 2*g);
		logic [63:0] rm_q, rs_q, t;
		assign t = sr_res[g] + BIT;
		always_ff @(posedge clk) if (en) begin
			if (sr_rem[g] >= t) begin
				rm_q <= sr_rem[g] - t;
				rs_q <= (sr_res[g] >> 1) + BIT;
			end else begin
				rm_q <= sr_rem[g];
				rs_q <= sr_res[g] >> 1;
			end
		end
		assign sr_rem[g+1] = rm_q;
		assign sr_res[g+1] = rs_q;
	end

	// restoring division (mag<<30 + norm/2)/norm; quotient fits 31 bits
	logic [31:0] nm [ND+1];
	logic [61:0] dv_r [ND+1][3];
	logic [30:0] dv_q [ND+1][3];
	assign nm[0] = sr_res[NS][31:0];
	for (genvar i = 0; i < 3; i++) begin : g_dinit
		assign dv_r[0][i] = (62'(mg[P1][i]) << 30) + 62'(sr_res[NS][31:1]);
		assign dv_q[0][i] = '0;
	end
	for (genvar g = 0; g < ND; g++) begin : g_div
		localparam int B = ND - 1 - g;
		logic [31:0] n_q;
		logic [61:0] r_q [3];
		logic [30:0] q_q [3];
		always_ff @(posedge clk) if (en) begin
			n_q <= nm[g];
			for (int i = 0; i < 3; i++) begin
				if (dv_r[g][i] >= (62'(nm[g]) << B)) begin
					r_q[i] <= dv_r[g][i] - (62'(nm[g]) << B);
					q_q[i] <= dv_q[g][i] | (31'd1 << B);
				end else begin
					r_q[i] <= dv_r[g][i];
					q_q[i] <= dv_q[g][i];
				end
			end
		end
		assign nm[g+1] = n_q;
		assign dv_r[g+1] = r_q;
		assign dv_q[g+1] = q_q;
	end

	// CORDIC running alongside; angle delayed into place
	logic [AW-1:0] ang_d [P2-NC+1];
	assign ang_d[0] = in_ang;
	for (genvar g = 0; g < P2 - NC; g++) begin : g_ad
		logic [AW-1:0] r_q;
		always_ff @(posedge clk) if (en) r_q <= ang_d[g];
		assign ang_d[g+1] = r_q;
	end
	logic [31:0] ph;
	logic [1:0] quad;
	logic [31:0] ru;
	assign ph = 32'(ang_d[P2-NC]) << (32 - AW);
	assign quad = 2'((ph + 32'h20000000) >> 30);
	assign ru = ph - (32'(quad) << 30);
	logic signed [33:0] cx [NC+1], cy [NC+1], cz [NC+1];
	logic [1:0] cq [NC+1];
	assign cx[0] = 34'(rva_pkg::CORDIC_X0);
	assign cy[0] = '0;
	assign cz[0] = 34'(signed'(ru));
	assign cq[0] = quad;
	for (genvar g = 0; g < NC; g++) begin : g_cor
		logic signed [33:0] x_q, y_q, z_q;
		logic [1:0] q_q;
		always_ff @(posedge clk) if (en) begin
			q_q <= cq[g];
			if (!cz[g][33]) begin
				x_q <= cx[g] - (cy[g] >>> g);
				y_q <= cy[g] + (cx[g] >>> g);
				z_q <= cz[g] - rva_pkg::atan_turn(g);
			end else begin
				x_q <= cx[g] + (cy[g] >>> g);
				y_q <= cy[g] - (cx[g] >>> g);
				z_q <= cz[g] + rva_pkg::atan_turn(g);
			end
		end
		assign cx[g+1] = x_q; assign cy[g+1] = y_q;
		assign cz[g+1] = z_q; assign cq[g+1] = q_q;
	end

	function automatic logic signed [33:0] clamp1(input logic signed [33:0] a);
		if (a > 34'(rva_pkg::UNIT_ONE)) return 34'(rva_pkg::UNIT_ONE);
		if (a < -34'(rva_pkg::UNIT_ONE)) return -34'(rva_pkg::UNIT_ONE);
		return a;
	endfunction

	// stage A: unit axis, cos, sin
	logic signed [33:0] k_a [3];
	logic signed [33:0] c_a, s_a, xc, yc;
	assign xc = clamp1(cx[NC]);
	assign yc = clamp1(cy[NC]);
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++)
			k_a[i] <= sd[P2].neg[i] ? -34'(dv_q[ND][i]) : 34'(dv_q[ND][i]);
		case (cq[NC])
			2'd0: begin c_a <= xc; s_a <= yc; end
			2'd1: begin c_a <= -yc; s_a <= xc; end
			2'd2: begin c_a <= -xc; s_a <= -yc; end
			default: begin c_a <= yc; s_a <= -xc; end
		endcase
	end
	// stage B: pair products
	logic signed [33:0] kk_b [3], kp_b [3], ks_b [3], c_b, u_b;
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) begin
			kk_b[i] <= rva_pkg::mulq(k_a[i], k_a[i]);
			ks_b[i] <= rva_pkg::mulq(k_a[i], s_a);
		end
		kp_b[0] <= rva_pkg::mulq(k_a[0], k_a[1]);
		kp_b[1] <= rva_pkg::mulq(k_a[0], k_a[2]);
		kp_b[2] <= rva_pkg::mulq(k_a[1], k_a[2]);
		c_b <= c_a;
		u_b <= 34'(rva_pkg::UNIT_ONE) - c_a;
	end
	// stage C: times cos / (1-cos)
	logic signed [33:0] kk_c [3], dg_c [3], op_c [3], ks_c [3];
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) begin
			kk_c[i] <= kk_b[i];
			dg_c[i] <= rva_pkg::mulq(34'(rva_pkg::UNIT_ONE) - kk_b[i], c_b);
			op_c[i] <= rva_pkg::mulq(kp_b[i], u_b);
			ks_c[i] <= ks_b[i];
		end
	end
	// stage D: matrix entries rounded to MF
	logic signed [33:0] m_d [3][3];
	function automatic logic signed [33:0] rnd(input logic signed [33:0] a);
		if (SH <= 0) return a;
		return (a + (34'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
	endfunction
	always_ff @(posedge clk) if (en) begin
		for (int i = 0; i < 3; i++) m_d[i][i] <= rnd(kk_c[i] + dg_c[i]);
		m_d[0][1] <= rnd(op_c[0] - ks_c[2]);
		m_d[0][2] <= rnd(op_c[1] + ks_c[1]);
		m_d[1][0] <= rnd(op_c[0] + ks_c[2]);
		m_d[1][2] <= rnd(op_c[2] - ks_c[0]);
		m_d[2][0] <= rnd(op_c[1] - ks_c[1]);
		m_d[2][1] <= rnd(op_c[2] + ks_c[0]);
	end
	// stage E: nine products
	localparam int PW = 34 + CW;
	logic signed [PW-1:0] p_e [3][3];
	logic signed [CW-1:0] vv [3];
	assign vv[0] = sd[P2+4].v[CW-1:0];
	assign vv[1] = sd[P2+4].v[2*CW-1:CW];
	assign vv[2] = sd[P2+4].v[3*CW-1:2*CW];
	always_ff @(posedge clk) if (en)
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p_e[i][j] <= PW'(m_d[i][j]) * PW'(vv[j]);
	// stage F: sum, round, saturate, or pass through
	logic signed [CW-1:0] r_f [3];
	logic signed [PW+1:0] acc [3];
	logic signed [PW+1:0] sh [3];
	always_comb
		for (int i = 0; i < 3; i++) begin
			acc[i] = (PW+2)'(p_e[i][0]) + (PW+2)'(p_e[i][1]) + (PW+2)'(p_e[i][2]);
			sh[i] = (acc[i] + ((PW+2)'(1) <<< (MF - 1))) >>> MF;
		end
	always_ff @(posedge clk) if (en)
		for (int i = 0; i < 3; i++) begin
			if (sd[P2+5].zero)
				r_f[i] <= sd[P2+5].v[i*CW +: CW];
			else if (sh[i] > $signed((PW+2)'({1'b0, {(CW-1){1'b1}}})))
				r_f[i] <= {1'b0, {(CW-1){1'b1}}};
			else if (sh[i] < -$signed((PW+2)'({1'b1, {(CW-1){1'b0}}})))
				r_f[i] <= {1'b1, {(CW-1){1'b0}}};
			else
				r_f[i] <= CW'(sh[i]);
		end
	assign out_valid = vld_q[NST-1];
	assign rx = r_f[0];
	assign ry = r_f[1];
	assign rz = r_f[2];
	assign zero = sd[NST].zero;
endmodule
`default_nettype wire

>>> src/rotate_vector_about_axis.sv
// Top level: rotates a vector about an arbitrary axis by a turn fraction.
// Depends on rva_pkg, rva_if, rva_front, rva_queue, rva_back.
//
// Usage: requests enter on in_ch (vector, axis, angle) and results leave on
// out_ch (rotated vector, zero_axis flag), both valid/ready channels.
// Throughput: one request per cycle when out_ch keeps ready high.
// Path of a request: 2 front stages, the queue's storage, then
// 70 back stages (2 square/sum, 31 root, 31 divide, 6 matrix/product).
// The root and divide pipelines produce one result bit per stage.
// Reset clears all valid flags; no request is in flight afterward.
// When the receiver stalls, the back pipeline holds, the queue fills, then
// the two front stages, and then in_ch.ready drops.
// A zero axis skips nothing in timing; the vector is passed through.
`default_nettype none
module rotate_vector_about_axis #(
	parameter int COMP_WIDTH = rva_pkg::COMP_WIDTH,
	parameter int ANGLE_BITS = rva_pkg::ANGLE_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	rva_if.sink   in_ch,
	rva_if.source out_ch
);
	localparam int CW = COMP_WIDTH;
	localparam int QW = 3*CW + 96 + 3 + 1 + ANGLE_BITS;
	logic f_valid, f_ready, b_valid, b_ready;
	logic [CW*3-1:0] f_v, b_v;
	logic [31:0] f_m0, f_m1, f_m2, b_m0, b_m1, b_m2;
	logic [2:0] f_neg, b_neg;
	logic f_zero, b_zero;
	logic [ANGLE_BITS-1:0] f_ang, b_ang;

	rva_front #(.CW(CW), .AW(ANGLE_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.vx(in_ch.data.vec_x), .vy(in_ch.data.vec_y), .vz(in_ch.data.vec_z),
		.ax(in_ch.data.axis_x), .ay(in_ch.data.axis_y), .az(in_ch.data.axis_z),
		.ang(in_ch.data.angle),
		.out_valid(f_valid), .out_ready(f_ready),
		.out_v(f_v), .out_m0(f_m0), .out_m1(f_m1), .out_m2(f_m2),
		.out_neg(f_neg), .out_zero(f_zero), .out_ang(f_ang)
	);

	rva_queue #(.W(QW), .DEPTH(4)) u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready),
		.in_data({f_v, f_m0, f_m1, f_m2, f_neg, f_zero, f_ang}),
		.out_valid(b_valid), .out_ready(b_ready),
		.out_data({b_v, b_m0, b_m1, b_m2, b_neg, b_zero, b_ang})
	);

	rva_back #(.CW(CW), .AW(ANGLE_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(b_valid), .in_ready(b_ready),
		.in_v(b_v), .in_m0(b_m0), .in_m1(b_m1), .in_m2(b_m2),
		.in_neg(b_neg), .in_zero(b_zero), .in_ang(b_ang),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.rx(out_ch.data.rot_x), .ry(out_ch.data.rot_y), .rz(out_ch.data.rot_z),
		.zero(out_ch.data.zero_axis)
	);
endmodule
`default_nettype wire

>>> src/rva_checker.sv
// Port checker for the rotation block, bound to the top level.
// Depends on rva_if through the top level's ports.
`default_nettype none
module rva_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic zero_axis
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_zero_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(zero_axis)) else $error("flag moved");
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid || arst_n) else $error("result after reset");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid) else $error("early result");
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready})) else $error("handshake unknown");
endmodule

bind rotate_vector_about_axis rva_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.zero_axis(out_ch.data.zero_axis)
);
`default_nettype wire
